// File: hw/rtl/mlfq_pkg.sv
// Shared constants, codes and the log table for the feedback-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

  localparam int LEVELS_DEF    = 8;
  localparam int THREADS_DEF   = 16;
  localparam int MAINT_RESET   = 40;
  localparam int MAIN_THREAD   = 2;
  localparam int MAINT_W       = 10;
  localparam int LN_W          = 18;
  localparam int PROD_W        = 34;   // 16-bit age times 18-bit log
  localparam int QUO_W         = 50;   // product shifted by 16
  localparam int DIV_W         = 27;   // positive decay denominator

  localparam logic KIND_INSERT   = 1'b0;
  localparam logic KIND_SCHEDULE = 1'b1;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // round(ln(n) * 2^16)
  function automatic logic [LN_W-1:0] lnq(input logic [4:0] n);
    logic [LN_W-1:0] v;
    case (n)
      5'd2:    v = 18'd45426;
      5'd3:    v = 18'd71999;
      5'd4:    v = 18'd90852;
      5'd5:    v = 18'd105476;
      5'd6:    v = 18'd117425;
      5'd7:    v = 18'd127527;
      5'd8:    v = 18'd136278;
      5'd9:    v = 18'd143997;
      5'd10:   v = 18'd150902;
      5'd11:   v = 18'd157148;
      5'd12:   v = 18'd162851;
      5'd13:   v = 18'd168097;
      5'd14:   v = 18'd172953;
      5'd15:   v = 18'd177475;
      5'd16:   v = 18'd181704;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] sat15(input int v);
    return (v > 15) ? 4'd15 : 4'(v);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mlfq_intf.sv
// Valid/ready channel interfaces for scheduler requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface mlfq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] thread_id;
  logic [2:0] level;
  logic [3:0] start_credit;
  logic [1:0] run_status;
  logic       yielded;
  logic       holds_lock;

  modport source (output valid, kind, thread_id, level, start_credit, run_status,
                  yielded, holds_lock, input ready);
  modport sink   (input valid, kind, thread_id, level, start_credit, run_status,
                  yielded, holds_lock, output ready);
endinterface

interface mlfq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] next_thread;
  logic [2:0] next_level;
  logic       idle;
  logic       continued;
  logic       retired_valid;
  logic [3:0] retired_thread;

  modport source (output valid, next_thread, next_level, idle, continued,
                  retired_valid, retired_thread, input ready);
  modport sink   (input valid, next_thread, next_level, idle, continued,
                  retired_valid, retired_thread, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mlfq_thread_scheduler.sv
// Multilevel feedback queue scheduler top level.
//
// in_ch carries insert beats (kind 0) and schedule-tick beats (kind 1); out_ch
// returns exactly one result beat per input beat. cfg_we/cfg_wdata load the
// maintenance period (ticks between decay passes) and should be written only
// while the block is idle.
// An insert never starts a decay pass. A tick that continues on credit
// skips the decay check; any other tick goes through it. A decay pass walks
// every thread queued at levels 1 and up; each thread whose decay
// denominator is positive goes through the 50-step shared restoring divider.
// in_ch.ready is high only while no beat is being worked on or held. A
// result waits in the output register until out_ch.ready; no new beat is
// taken meanwhile. Reset empties all levels, clears tick count, loads a
// period of 40 and leaves no thread running. No memory clearing is needed.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_thread_scheduler #(
  parameter int LEVELS      = mlfq_pkg::LEVELS_DEF,
  parameter int MAX_THREADS = mlfq_pkg::THREADS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mlfq_in_if.sink                          in_ch,
  mlfq_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [mlfq_pkg::MAINT_W-1:0] cfg_wdata
);
  localparam int TW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(LEVELS);

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_TICK, S_APP, S_DCHK, S_LVL, S_MUL, S_DST, S_DIVW,
    S_MOVE, S_CHOOSE, S_REP, S_OUT
  } state_t;

  state_t state_r, app_ret_r;

  logic [TW-1:0]  head_r [LEVELS];
  logic [TW-1:0]  tail_r [LEVELS];
  logic [LEVELS-1:0] empty_r;
  logic [TW-1:0]  link_r [MAX_THREADS];
  logic [3:0]     credit_r [MAX_THREADS];
  logic [31:0]    last_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] queued_r;

  logic [31:0]    tick_r;
  logic signed [10:0] cdown_r;
  logic [mlfq_pkg::MAINT_W-1:0] maint_r;
  logic [LW-1:0]  rl_r;
  logic           running_r;

  // latched request
  logic [3:0]     tid_r;
  logic [2:0]     lvin_r;
  logic [3:0]     scred_r;
  logic [1:0]     stat_r;
  logic           yld_r;
  logic           lock_r;

  // append helper
  logic [TW-1:0]  app_t_r;
  logic [LW-1:0]  app_lv_r;

  // decay walk
  logic [LW:0]    lvl_r;
  logic [TW-1:0]  cur_r, nxt_r, prev_r;
  logic           hp_r, last_r_f;
  logic [LW-1:0]  nl_r;
  logic [mlfq_pkg::PROD_W-1:0] prod_r;
  logic [mlfq_pkg::DIV_W-1:0]  dvs_r;

  // result register
  logic           ov_r;
  logic [3:0]     o_thr_r, o_ret_r;
  logic [2:0]     o_lvl_r;
  logic           o_idle_r, o_cont_r, o_retv_r;

  logic           div_done;
  logic [mlfq_pkg::QUO_W-1:0] div_q;

  mlfq_div #(.DW(mlfq_pkg::QUO_W), .VW(mlfq_pkg::DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DST),
    .dividend ({prod_r, 16'd0}),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // walk helpers
  logic [LW-1:0]  lvl_i;
  logic [4:0]     lvl_p1;
  logic [mlfq_pkg::LN_W-1:0] ln_top;
  logic [31:0]    age;
  logic [15:0]    age_c;
  logic signed [11:0] cs;
  logic signed [29:0] dval;
  logic           d_pos;
  logic [LW-1:0]  nl_calc;
  logic [LW-1:0]  ins_lv;
  logic [LW-1:0]  first_lv;
  logic [TW-1:0]  run_t;

  assign lvl_i  = LW'(lvl_r);
  assign lvl_p1 = 5'(lvl_r) + 5'd1;
  assign ln_top = mlfq_pkg::lnq(lvl_p1);
  assign age    = tick_r - last_r[cur_r];
  assign age_c  = (|age[31:16]) ? 16'hFFFF : age[15:0];
  assign cs     = 12'({2'b00, maint_r}) - 12'(cdown_r);
  assign dval   = {{2{cs[11]}}, cs, 16'd0} - 30'(ln_top);
  assign d_pos  = !dval[29] && (|dval);
  assign run_t  = head_r[rl_r];

  always_comb begin
    nl_calc = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if (k <= int'(lvl_r) &&
          div_q <= mlfq_pkg::QUO_W'(ln_top - mlfq_pkg::lnq(5'(k))))
        nl_calc = LW'(k);
    end
  end

  always_comb begin
    first_lv = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (!empty_r[k]) first_lv = LW'(k);
    end
  end

  assign ins_lv = (int'(lvin_r) >= LEVELS) ? LW'(LEVELS - 1) : LW'(lvin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      app_ret_r <= S_IDLE;
      empty_r   <= '1;
      queued_r  <= '0;
      tick_r    <= '0;
      maint_r   <= mlfq_pkg::MAINT_W'(mlfq_pkg::MAINT_RESET);
      cdown_r   <= 11'(mlfq_pkg::MAINT_RESET);
      rl_r      <= '0;
      running_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) maint_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            tid_r    <= in_ch.thread_id;
            lvin_r   <= in_ch.level;
            scred_r  <= in_ch.start_credit;
            stat_r   <= in_ch.run_status;
            yld_r    <= in_ch.yielded;
            lock_r   <= in_ch.holds_lock;
            o_cont_r <= 1'b0;
            o_retv_r <= 1'b0;
            o_ret_r  <= '0;
            state_r  <= (in_ch.kind == mlfq_pkg::KIND_INSERT) ? S_INS : S_TICK;
          end
        end
        S_INS: begin
          if (int'(tid_r) < MAX_THREADS && !queued_r[TW'(tid_r)]) begin
            queued_r[TW'(tid_r)] <= 1'b1;
            credit_r[TW'(tid_r)] <= scred_r;
            last_r[TW'(tid_r)]   <= tick_r;
            app_t_r   <= TW'(tid_r);
            app_lv_r  <= ins_lv;
            app_ret_r <= S_REP;
            state_r   <= S_APP;
          end else begin
            state_r <= S_REP;
          end
        end
        S_TICK: begin
          tick_r <= tick_r + 32'd1;
          if (cdown_r != -11'sd1024) cdown_r <= cdown_r - 11'sd1;
          if (running_r && !empty_r[rl_r]) begin
            last_r[run_t] <= tick_r;
            if (stat_r == mlfq_pkg::ST_READY && !yld_r && credit_r[run_t] != 4'd0) begin
              credit_r[run_t] <= credit_r[run_t] - 4'd1;
              o_thr_r  <= 4'(run_t);
              o_lvl_r  <= 3'(rl_r);
              o_idle_r <= 1'b0;
              o_cont_r <= 1'b1;
              ov_r     <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              // pop the head
              if (run_t == tail_r[rl_r]) empty_r[rl_r] <= 1'b1;
              else head_r[rl_r] <= link_r[run_t];
              if (stat_r == mlfq_pkg::ST_READY) begin
                app_t_r   <= run_t;
                app_ret_r <= S_DCHK;
                state_r   <= S_APP;
                if (yld_r || lock_r) begin
                  credit_r[run_t] <= mlfq_pkg::sat15(int'(rl_r));
                  app_lv_r <= rl_r;
                end else if (int'(rl_r) >= LEVELS - 1) begin
                  credit_r[run_t] <= mlfq_pkg::sat15(LEVELS - 1);
                  app_lv_r <= rl_r;
                end else begin
                  credit_r[run_t] <= mlfq_pkg::sat15(int'(rl_r) + 2);
                  app_lv_r <= rl_r + 1'b1;
                end
              end else begin
                queued_r[run_t] <= 1'b0;
                state_r <= S_DCHK;
                if (stat_r == mlfq_pkg::ST_DONE && int'(run_t) != mlfq_pkg::MAIN_THREAD) begin
                  o_retv_r <= 1'b1;
                  o_ret_r  <= 4'(run_t);
                end
              end
            end
          end else begin
            state_r <= S_DCHK;
          end
        end
        S_APP: begin
          if (empty_r[app_lv_r]) begin
            head_r[app_lv_r]  <= app_t_r;
            empty_r[app_lv_r] <= 1'b0;
          end else begin
            link_r[tail_r[app_lv_r]] <= app_t_r;
          end
          tail_r[app_lv_r] <= app_t_r;
          state_r <= app_ret_r;
        end
        S_DCHK: begin
          lvl_r   <= (LW + 1)'(1);
          state_r <= (cdown_r <= 11'sd0) ? S_LVL : S_CHOOSE;
        end
        S_LVL: begin
          if (int'(lvl_r) >= LEVELS) begin
            cdown_r <= 11'({1'b0, maint_r});
            state_r <= S_CHOOSE;
          end else if (empty_r[lvl_i]) begin
            lvl_r <= lvl_r + 1'b1;
          end else begin
            cur_r   <= head_r[lvl_i];
            hp_r    <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          last_r_f <= (cur_r == tail_r[lvl_i]);
          nxt_r    <= link_r[cur_r];
          prod_r   <= mlfq_pkg::PROD_W'(age_c * ln_top);
          dvs_r    <= dval[mlfq_pkg::DIV_W-1:0];
          if (d_pos) begin
            state_r <= S_DST;
          end else begin
            nl_r    <= lvl_i;
            state_r <= S_MOVE;
          end
        end
        S_DST: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            nl_r    <= nl_calc;
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (nl_r < lvl_i) begin
            // unlink from this level, then append below
            if (!hp_r) begin
              if (last_r_f) empty_r[lvl_i] <= 1'b1;
              else head_r[lvl_i] <= nxt_r;
            end else begin
              link_r[prev_r] <= nxt_r;
              if (last_r_f) tail_r[lvl_i] <= prev_r;
            end
            app_t_r   <= cur_r;
            app_lv_r  <= nl_r;
            app_ret_r <= last_r_f ? S_LVL : S_MUL;
            state_r   <= S_APP;
          end else begin
            prev_r  <= cur_r;
            hp_r    <= 1'b1;
            state_r <= last_r_f ? S_LVL : S_MUL;
          end
          if (last_r_f) lvl_r <= lvl_r + 1'b1;
          else cur_r <= nxt_r;
        end
        S_CHOOSE: begin
          running_r <= !(&empty_r);
          rl_r      <= (&empty_r) ? rl_r : first_lv;
          state_r   <= S_REP;
        end
        S_REP: begin
          if (running_r && !empty_r[rl_r]) begin
            o_thr_r  <= 4'(run_t);
            o_lvl_r  <= 3'(rl_r);
            o_idle_r <= 1'b0;
          end else begin
            o_thr_r  <= '0;
            o_lvl_r  <= '0;
            o_idle_r <= 1'b1;
          end
          ov_r    <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ov_r    <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = ov_r;
  assign out_ch.next_thread    = o_thr_r;
  assign out_ch.next_level     = o_lvl_r;
  assign out_ch.idle           = o_idle_r;
  assign out_ch.continued      = o_cont_r;
  assign out_ch.retired_valid  = o_retv_r;
  assign out_ch.retired_thread = o_ret_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("beat taken while result pending");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.idle) |-> (out_ch.next_thread == 4'd0 && !out_ch.continued))
    else $error("idle result names a thread");
  a_cont_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.continued && out_ch.retired_valid))
    else $error("continued and retired together");
  a_div_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW) else $error("divider result outside walk");
endmodule
`default_nettype wire

// File: hw/rtl/mlfq_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_div #(
  parameter int DW = mlfq_pkg::QUO_W,
  parameter int VW = mlfq_pkg::DIV_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted  = {rem_r, q_r[DW-1]};
  assign fits     = shifted >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? VW'(shifted - {1'b0, dvs_r}) : VW'(shifted);
        q_r   <= {q_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |-> cnt_r != '0) else $error("divider count underflow");
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  typedef struct packed {
    logic [3:0] next_thread;
    logic [2:0] next_level;
    logic       idle;
    logic       continued;
    logic       retired_valid;
    logic [3:0] retired_thread;
  } sched_res_t;

  localparam int NLVL = mlfq_pkg::LEVELS_DEF;
  localparam int NTHR = mlfq_pkg::THREADS_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mlfq_pkg::MAINT_W-1:0] cfg_wdata;

  mlfq_in_if  in_ch();
  mlfq_out_if out_ch();

  mlfq_thread_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  lv_head [NLVL];
  logic [3:0]  lv_tail [NLVL];
  logic        lv_empty [NLVL];
  logic [3:0]  nxt_link [NTHR];
  logic [2:0]  thr_level [NTHR];
  logic [3:0]  thr_credit [NTHR];
  logic [31:0] thr_last [NTHR];
  logic        thr_queued [NTHR];
  logic [31:0] ticks;
  int          countdown;
  logic [2:0]  run_lvl;
  logic        is_running;
  int          period;

  sched_res_t expected_q[$];
  int errors;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  function automatic logic [31:0] ln_q16(input int n);
    case (n)
      2: return 45426;   3: return 71999;   4: return 90852;   5: return 105476;
      6: return 117425;  7: return 127527;  8: return 136278;  9: return 143997;
      10: return 150902; 11: return 157148; 12: return 162851; 13: return 168097;
      14: return 172953; 15: return 177475; 16: return 181704;
      default: return 0;
    endcase
  endfunction

  function automatic logic [3:0] cap15(input int v);
    return (v > 15) ? 4'd15 : v[3:0];
  endfunction

  task automatic q_append(input int t, input int lv);
    if (lv_empty[lv]) begin
      lv_head[lv] = 4'(t);
      lv_empty[lv] = 1'b0;
    end else begin
      nxt_link[lv_tail[lv]] = 4'(t);
    end
    lv_tail[lv] = 4'(t);
  endtask

  function automatic int decayed_level(input int lv, input logic [31:0] age, input int cs);
    longint d;
    longint unsigned xc, e, li;
    li = ln_q16(lv + 1);
    d = longint'(cs) * 65536 - longint'(li);
    if (d <= 0) return lv;
    xc = (age > 65535) ? 65535 : age;
    e = ((xc * li) << 16) / longint'(d);
    for (int k = lv; k >= 1; k--)
      if (li - ln_q16(k) >= e) return k;
    return 0;
  endfunction

  task automatic decay_all();
    int cs, cur, prv, nl;
    bit have_prv, last;
    logic [3:0] nx;
    cs = period - countdown;
    for (int i = 1; i < NLVL; i++) begin
      if (lv_empty[i]) continue;
      cur = lv_head[i];
      have_prv = 0;
      prv = 0;
      for (int g = 0; g < NTHR; g++) begin
        last = (cur == lv_tail[i]);
        nx = nxt_link[cur];
        nl = decayed_level(i, ticks - thr_last[cur], cs);
        if (nl < i) begin
          if (!have_prv) begin
            if (last) lv_empty[i] = 1'b1;
            else lv_head[i] = nx;
          end else begin
            nxt_link[prv] = nx;
            if (last) lv_tail[i] = 4'(prv);
          end
          thr_level[cur] = 3'(nl);
          q_append(cur, nl);
        end else begin
          prv = cur;
          have_prv = 1;
        end
        if (last) break;
        cur = nx;
      end
    end
  endtask

  function automatic sched_res_t current_running();
    sched_res_t r;
    r = '0;
    if (is_running && !lv_empty[run_lvl]) begin
      r.next_thread = lv_head[run_lvl];
      r.next_level = run_lvl;
    end else begin
      r.idle = 1'b1;
    end
    return r;
  endfunction

  task automatic tick_time();
    ticks++;
    if (countdown > -1024) countdown--;
  endtask

  task automatic predict_step(input logic kind, input logic [3:0] tid, input logic [2:0] lvl,
                              input logic [3:0] cred, input logic [1:0] st,
                              input logic yld, input logic lck, output sched_res_t r);
    int lv, t;
    sched_res_t retire;
    retire = '0;
    if (kind == mlfq_pkg::KIND_INSERT) begin
      if (!thr_queued[tid]) begin
        thr_queued[tid] = 1'b1;
        thr_level[tid] = lvl;
        thr_credit[tid] = cred;
        thr_last[tid] = ticks;
        q_append(tid, lvl);
      end
      r = current_running();
      return;
    end
    if (is_running && !lv_empty[run_lvl]) begin
      lv = run_lvl;
      t = lv_head[lv];
      thr_last[t] = ticks;
      tick_time();
      if (st == mlfq_pkg::ST_READY) begin
        if (!yld && thr_credit[t] > 0) begin
          thr_credit[t]--;
          r = '0;
          r.next_thread = 4'(t);
          r.next_level = 3'(lv);
          r.continued = 1'b1;
          return;
        end
        if (lv_head[lv] == lv_tail[lv]) lv_empty[lv] = 1'b1;
        else lv_head[lv] = nxt_link[t];
        if (yld || lck) thr_credit[t] = cap15(lv);
        else if (lv >= NLVL - 1) begin
          lv = NLVL - 1;
          thr_credit[t] = cap15(NLVL - 1);
        end else begin
          lv++;
          thr_credit[t] = cap15(lv + 1);
        end
        thr_level[t] = 3'(lv);
        q_append(t, lv);
      end else begin
        if (lv_head[lv] == lv_tail[lv]) lv_empty[lv] = 1'b1;
        else lv_head[lv] = nxt_link[t];
        thr_queued[t] = 1'b0;
        if (st == mlfq_pkg::ST_DONE && t != mlfq_pkg::MAIN_THREAD) begin
          retire.retired_valid = 1'b1;
          retire.retired_thread = 4'(t);
        end
      end
    end else begin
      tick_time();
    end
    if (countdown <= 0) begin
      decay_all();
      countdown = period;
    end
    is_running = 1'b0;
    for (int i = 0; i < NLVL; i++)
      if (!lv_empty[i]) begin
        run_lvl = 3'(i);
        is_running = 1'b1;
        break;
      end
    r = current_running();
    r.retired_valid = retire.retired_valid;
    r.retired_thread = retire.retired_thread;
  endtask

  task automatic model_reset();
    for (int i = 0; i < NLVL; i++) begin
      lv_head[i] = '0; lv_tail[i] = '0; lv_empty[i] = 1'b1;
    end
    for (int i = 0; i < NTHR; i++) begin
      nxt_link[i] = '0; thr_level[i] = '0; thr_credit[i] = '0;
      thr_last[i] = '0; thr_queued[i] = 1'b0;
    end
    period = mlfq_pkg::MAINT_RESET;
    ticks = '0;
    countdown = period;
    run_lvl = '0;
    is_running = 1'b0;
  endtask

  // one beat on the request channel; prediction happens at acceptance
  task automatic send_beat(input logic kind, input logic [3:0] tid, input logic [2:0] lvl,
                           input logic [3:0] cred, input logic [1:0] st,
                           input logic yld, input logic lck);
    sched_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.thread_id <= tid;
    in_ch.level <= lvl;
    in_ch.start_credit <= cred;
    in_ch.run_status <= st;
    in_ch.yielded <= yld;
    in_ch.holds_lock <= lck;
    do @(posedge clk); while (!in_ch.ready);
    predict_step(kind, tid, lvl, cred, st, yld, lck, r);
    expected_q.push_back(r);
  endtask

  task automatic insert_thread(input int tid, input int lvl, input int cred);
    send_beat(mlfq_pkg::KIND_INSERT, 4'(tid), 3'(lvl), 4'(cred), mlfq_pkg::ST_READY,
              1'b0, 1'b0);
  endtask

  task automatic tick(input int st, input bit yld, input bit lck);
    send_beat(mlfq_pkg::KIND_SCHEDULE, 4'($urandom_range(15)), 3'($urandom_range(7)),
              4'($urandom_range(15)), 2'(st), yld, lck);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_period(input int p);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= mlfq_pkg::MAINT_W'(p);
    @(posedge clk);
    cfg_we <= 1'b0;
    period = p;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sched_res_t got, exp_r;
        got = '{out_ch.next_thread, out_ch.next_level, out_ch.idle, out_ch.continued,
                out_ch.retired_valid, out_ch.retired_thread};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected thr=%0d lvl=%0d idle=%0d cont=%0d ret=%0d/%0d",
                     $time, exp_r.next_thread, exp_r.next_level, exp_r.idle,
                     exp_r.continued, exp_r.retired_valid, exp_r.retired_thread);
            $display("%0t:          actual   thr=%0d lvl=%0d idle=%0d cont=%0d ret=%0d/%0d",
                     $time, got.next_thread, got.next_level, got.idle,
                     got.continued, got.retired_valid, got.retired_thread);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on acceptance activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (expected_q.size() == 0 && !in_ch.valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    tick(mlfq_pkg::ST_READY, 0, 0);       // tick with nothing queued
    insert_thread(15, 7, 15);
    insert_thread(0, 0, 0);
    insert_thread(2, 0, 8);
    insert_thread(0, 3, 1);               // already queued: ignored
    tick(mlfq_pkg::ST_READY, 0, 0);       // nothing running yet: first pick
    tick(mlfq_pkg::ST_READY, 0, 0);       // ready, no credit: ages down
    tick(mlfq_pkg::ST_READY, 1, 0);       // yield resets credit to the level
    tick(mlfq_pkg::ST_DONE, 0, 0);        // main thread done: no report
    tick(mlfq_pkg::ST_READY, 0, 1);       // credit left: continues despite lock
    insert_thread(9, 7, 0);
    tick(mlfq_pkg::ST_READY, 0, 0);
    tick(mlfq_pkg::ST_BLOCKED, 0, 0);
    tick(mlfq_pkg::ST_UNKNOWN, 0, 0);     // acts as blocked
    tick(mlfq_pkg::ST_DONE, 0, 0);
    repeat (6) tick(mlfq_pkg::ST_READY, 0, 0);
    tick(mlfq_pkg::ST_DONE, 1, 1);
  endtask

  task automatic test_random(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30) insert_thread($urandom_range(15), $urandom_range(7), $urandom_range(15));
      else tick(($urandom_range(9) < 7) ? int'(mlfq_pkg::ST_READY) : $urandom_range(1, 3),
                $urandom_range(3) == 0, $urandom_range(3) == 0);
      if (k == n / 2) drain();            // sender holds off until all results are back
    end
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 36;
    recv_idle_pct = 63;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.thread_id = '0;
    in_ch.level = '0;
    in_ch.start_credit = '0;
    in_ch.run_status = '0;
    in_ch.yielded = 1'b0;
    in_ch.holds_lock = 1'b0;
    out_ch.ready = 1'b0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_period(1);
    test_random(150);
    send_idle_pct = 63;
    recv_idle_pct = 36;
    write_period(1023);
    test_random(150);
    write_period(3);
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_period($urandom_range(4, 60));
    test_random(180);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
